>>> sv/lane_position_vote_core_assert.svh
// assertion macros for the lane position vote checker
`ifndef LANE_POSITION_VOTE_CORE_ASSERT_SVH
`define LANE_POSITION_VOTE_CORE_ASSERT_SVH

// clocked assertion with synchronous active-low reset as disable
`define LPV_ASSERT(label, clock, resetn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) (prop)) else $error(msg);

// same, on the default clk and rst_n of the calling scope
`define LPV_ASSERT_CORE(label, prop, msg) \
  `LPV_ASSERT(label, clk, rst_n, prop, msg)

`endif

>>> sv/lpv_pkg.sv
// types, constants and codes shared by the lane position vote files
package lpv_pkg;

  localparam int HISTORY_DEPTH_DEF = 55;
  localparam int COORD_BITS_DEF    = 12;
  localparam int COUNT_BITS_DEF    = 10;

  localparam int SPLIT_BITS  = 12;
  localparam int THRESH_BITS = 8;
  localparam int TAN_BITS    = 16;
  localparam int MARKS_BITS  = 10;
  localparam int TALLY_BITS  = 6;
  localparam int CLASS_BITS  = 2;
  localparam int CLASS_COUNT = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [SPLIT_BITS-1:0]  SPLIT_RESET     = SPLIT_BITS'(1050);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET    = THRESH_BITS'(0);
  localparam logic [TAN_BITS-1:0]    TAN_LOW_RESET   = TAN_BITS'(6888);
  localparam logic [TAN_BITS-1:0]    TAN_HIGH_RESET  = TAN_BITS'(13930);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPLIT_COLUMN     = 2'd0,
    CFG_COUNT_THRESHOLD  = 2'd1,
    CFG_TANGENT_LOW_Q16  = 2'd2,
    CFG_TANGENT_HIGH_Q16 = 2'd3
  } lpv_cfg_idx_t;

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_LEFT   = 2'd0,
    CLS_MIDDLE = 2'd1,
    CLS_RIGHT  = 2'd2,
    CLS_NONE   = 2'd3
  } lpv_class_t;

  // one decided frame, handed to the history unit
  typedef struct packed {
    lpv_class_t            frame_class;
    logic [MARKS_BITS-1:0] left_marks;
    logic [MARKS_BITS-1:0] right_marks;
  } lpv_frame_t;

  // frame plus the vote over the ring after it was recorded
  typedef struct packed {
    lpv_frame_t frame;
    lpv_class_t voted_class;
  } lpv_result_t;

endpackage

>>> sv/lane_position_vote_core.sv
// top level of the lane position voter
//
// usage: segments stream in on the in_ channel, one beat per cycle while
// in_ready is high, each with a segment_valid flag and a frame_end mark. a valid
// segment counts toward the left or right marking count depending on its midpoint
// column against split_column and on its slope, tested by cross-multiplying
// against the q16 tangent bounds. the beat with frame_end set closes the frame
// and yields one result beat on the out_ channel: frame class, majority vote over
// the class ring and the frame's two marking counts. other beats yield nothing.
// path: an accepted frame-end beat passes the input, multiply, compare, count and
// ring update stages, then the output register, before it shows up at out_valid.
// throughput: one input beat every cycle while the pipe is not held by a stall;
// the ring entry to be replaced is read ahead and a same-entry write is
// forwarded, so back to back frame ends need no bubble.
// reset: counts, tallies, pointer and config registers return to defaults; the
// ring reads as empty through a wrapped flag, so no clearing pass is needed.
// stall: a result waiting in the output register blocks the pipe only when the
// next result reaches the last stage; plain segment beats keep flowing.
// config: cfg_ writes are always ready and are meant for an idle block.
module lane_position_vote_core #(
  parameter int HISTORY_DEPTH = lpv_pkg::HISTORY_DEPTH_DEF,
  parameter int COORD_BITS    = lpv_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS    = lpv_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // segment channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              in_start_x,
  input  logic [COORD_BITS-1:0]              in_start_y,
  input  logic [COORD_BITS-1:0]              in_end_x,
  input  logic [COORD_BITS-1:0]              in_end_y,
  input  logic                               in_segment_valid,
  input  logic                               in_frame_end,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lpv_pkg::CLASS_BITS-1:0]     out_frame_class,
  output logic [lpv_pkg::CLASS_BITS-1:0]     out_voted_class,
  output logic [lpv_pkg::MARKS_BITS-1:0]     out_left_marks,
  output logic [lpv_pkg::MARKS_BITS-1:0]     out_right_marks,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lpv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int MID_W  = (COORD_BITS > lpv_pkg::SPLIT_BITS) ? COORD_BITS
                                                             : lpv_pkg::SPLIT_BITS;
  localparam int PROD_W = lpv_pkg::TAN_BITS + COORD_BITS;
  localparam int THR_W  = (COUNT_BITS > lpv_pkg::THRESH_BITS) ? COUNT_BITS
                                                              : lpv_pkg::THRESH_BITS;

  // configuration registers
  logic [lpv_pkg::SPLIT_BITS-1:0]  split_r;
  logic [lpv_pkg::THRESH_BITS-1:0] thresh_r;
  logic [lpv_pkg::TAN_BITS-1:0]    tan_low_r;
  logic [lpv_pkg::TAN_BITS-1:0]    tan_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r    <= lpv_pkg::SPLIT_RESET;
      thresh_r   <= lpv_pkg::THRESH_RESET;
      tan_low_r  <= lpv_pkg::TAN_LOW_RESET;
      tan_high_r <= lpv_pkg::TAN_HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (lpv_pkg::lpv_cfg_idx_t'(cfg_index))
        lpv_pkg::CFG_SPLIT_COLUMN:     split_r    <= cfg_data[lpv_pkg::SPLIT_BITS-1:0];
        lpv_pkg::CFG_COUNT_THRESHOLD:  thresh_r   <= cfg_data[lpv_pkg::THRESH_BITS-1:0];
        lpv_pkg::CFG_TANGENT_LOW_Q16:  tan_low_r  <= cfg_data[lpv_pkg::TAN_BITS-1:0];
        lpv_pkg::CFG_TANGENT_HIGH_Q16: tan_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advance: hold only when a result meets a full, stalled output register
  logic                  en;
  logic                  e_vld;
  lpv_pkg::lpv_result_t  e_res;
  logic                  out_valid_r;

  assign en       = !(out_valid_r && !out_ready && e_vld);
  assign in_ready = en;

  // input stage: direction, side, run and rise of the segment
  logic                  in_fire;
  logic                  dir_fwd;
  logic [COORD_BITS:0]   mid_sum;
  logic [MID_W-1:0]      mid_ext;
  logic                  side_left;
  logic                  dir_ok;
  logic [COORD_BITS-1:0] run;
  logic [COORD_BITS-1:0] rise;

  assign in_fire   = in_valid && in_ready;
  assign dir_fwd   = in_end_x > in_start_x;
  assign run       = in_end_x - in_start_x;
  assign mid_sum   = {1'b0, in_start_x} + {1'b0, in_end_x};
  assign mid_ext   = MID_W'(mid_sum[COORD_BITS:1]);
  assign side_left = mid_ext < MID_W'(split_r);
  // left markings climb toward smaller rows, right markings toward larger
  assign dir_ok    = side_left ? (in_end_y < in_start_y) : (in_end_y > in_start_y);
  assign rise      = side_left ? (in_start_y - in_end_y) : (in_end_y - in_start_y);

  logic                  a_vld_r, a_fend_r;
  logic                  a_seg_r, a_left_r;
  logic [COORD_BITS-1:0] a_run_r, a_rise_r;

  // multiply stage: both tangent bounds scaled by the run, rise shifted to q16
  logic                  b_vld_r, b_fend_r;
  logic                  b_seg_r, b_left_r;
  logic [PROD_W-1:0]     b_lo_r, b_hi_r, b_scaled_r;

  // compare stage: segment hits
  logic                  c_vld_r, c_fend_r;
  logic                  c_hit_l_r, c_hit_r_r;
  logic                  in_band;

  assign in_band = (b_lo_r < b_scaled_r) && (b_scaled_r < b_hi_r);

  // count stage
  logic [COUNT_BITS-1:0] left_cnt_r, right_cnt_r;
  logic [COUNT_BITS-1:0] left_cnt_nxt, right_cnt_nxt;
  logic                  d_vld_r;
  lpv_pkg::lpv_frame_t   d_frame_r;
  lpv_pkg::lpv_class_t   frame_cls;
  logic                  left_present, right_present;

  // saturating increments, the frame-end beat's own segment included
  assign left_cnt_nxt  = (c_hit_l_r && left_cnt_r != '1) ?
                         left_cnt_r + COUNT_BITS'(1) : left_cnt_r;
  assign right_cnt_nxt = (c_hit_r_r && right_cnt_r != '1) ?
                         right_cnt_r + COUNT_BITS'(1) : right_cnt_r;
  assign left_present  = THR_W'(left_cnt_nxt) > THR_W'(thresh_r);
  assign right_present = THR_W'(right_cnt_nxt) > THR_W'(thresh_r);

  // camera sits right of a lone left marking, and the other way round
  always_comb begin
    priority if (left_present && right_present) begin
      frame_cls = lpv_pkg::CLS_MIDDLE;
    end else if (left_present) begin
      frame_cls = lpv_pkg::CLS_RIGHT;
    end else if (right_present) begin
      frame_cls = lpv_pkg::CLS_LEFT;
    end else begin
      frame_cls = lpv_pkg::CLS_NONE;
    end
  end

  // control state of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
    end else if (en) begin
      a_vld_r <= in_fire;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      // only frame-end beats travel past the count stage
      d_vld_r <= c_vld_r && c_fend_r;
      if (c_vld_r) begin
        if (c_fend_r) begin
          left_cnt_r  <= '0;
          right_cnt_r <= '0;
        end else begin
          left_cnt_r  <= left_cnt_nxt;
          right_cnt_r <= right_cnt_nxt;
        end
      end
    end
  end

  // payload of the stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_fend_r   <= in_frame_end;
      a_seg_r    <= in_segment_valid && dir_fwd && dir_ok;
      a_left_r   <= side_left;
      a_run_r    <= run;
      a_rise_r   <= rise;

      b_fend_r   <= a_fend_r;
      b_seg_r    <= a_seg_r;
      b_left_r   <= a_left_r;
      b_lo_r     <= PROD_W'(tan_low_r) * PROD_W'(a_run_r);
      b_hi_r     <= PROD_W'(tan_high_r) * PROD_W'(a_run_r);
      b_scaled_r <= {a_rise_r, {lpv_pkg::TAN_BITS{1'b0}}};

      c_fend_r   <= b_fend_r;
      c_hit_l_r  <= b_vld_r && b_seg_r && b_left_r && in_band;
      c_hit_r_r  <= b_vld_r && b_seg_r && !b_left_r && in_band;

      d_frame_r.frame_class <= frame_cls;
      d_frame_r.left_marks  <= lpv_pkg::MARKS_BITS'(left_cnt_nxt);
      d_frame_r.right_marks <= lpv_pkg::MARKS_BITS'(right_cnt_nxt);
    end
  end

  // ring update and vote
  lpv_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (en),
    .frame_vld (d_vld_r),
    .frame     (d_frame_r),
    .res_vld   (e_vld),
    .res       (e_res)
  );

  // output register
  lpv_pkg::lpv_result_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && e_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && e_vld) begin
      out_res_r <= e_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_class = out_res_r.frame.frame_class;
  assign out_voted_class = out_res_r.voted_class;
  assign out_left_marks  = out_res_r.frame.left_marks;
  assign out_right_marks = out_res_r.frame.right_marks;

endmodule

>>> sv/lpv_history.sv
// class history ring in a synchronous memory, running tallies and majority vote
module lpv_history #(
  parameter int HISTORY_DEPTH = lpv_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 frame_vld,
  input  lpv_pkg::lpv_frame_t  frame,
  output logic                 res_vld,
  output lpv_pkg::lpv_result_t res
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  logic [lpv_pkg::CLASS_BITS-1:0] mem [HISTORY_DEPTH];

  logic [PTR_W-1:0]               ptr_r, ptr_nxt;
  logic                           wrapped_r;
  logic [lpv_pkg::CLASS_BITS-1:0] rd_data_r;
  logic                           fwd_r;
  logic [lpv_pkg::CLASS_BITS-1:0] fwd_data_r;
  logic [lpv_pkg::TALLY_BITS-1:0] tally_r   [lpv_pkg::CLASS_COUNT];
  logic [lpv_pkg::TALLY_BITS-1:0] tally_nxt [lpv_pkg::CLASS_COUNT];
  logic                           e_vld_r;
  lpv_pkg::lpv_frame_t            e_frame_r;

  logic                           wr_en;
  logic [lpv_pkg::CLASS_BITS-1:0] old_cls;
  lpv_pkg::lpv_class_t            win;

  assign wr_en   = adv && frame_vld;
  assign ptr_nxt = !wr_en ? ptr_r : ((ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1));
  // entry under the pointer was written only once the ring has wrapped
  assign old_cls = fwd_r ? fwd_data_r : rd_data_r;

  // read the entry the next frame end will replace
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr_r] <= frame.frame_class;
    end
    rd_data_r  <= mem[ptr_nxt];
    fwd_data_r <= frame.frame_class;
  end

  always_comb begin
    logic [lpv_pkg::TALLY_BITS-1:0] t;
    t = '0;
    for (int i = 0; i < lpv_pkg::CLASS_COUNT; i++) begin
      t = tally_r[i];
      if (wrapped_r && old_cls == lpv_pkg::CLASS_BITS'(i) && t != '0) begin
        t = t - lpv_pkg::TALLY_BITS'(1);
      end
      if (frame.frame_class == lpv_pkg::CLASS_BITS'(i)) begin
        t = t + lpv_pkg::TALLY_BITS'(1);
      end
      tally_nxt[i] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      fwd_r     <= 1'b0;
      e_vld_r   <= 1'b0;
      for (int i = 0; i < lpv_pkg::CLASS_COUNT; i++) begin
        tally_r[i] <= '0;
      end
    end else begin
      fwd_r <= wr_en && (ptr_nxt == ptr_r);
      if (adv) begin
        e_vld_r <= frame_vld;
      end
      if (wr_en) begin
        ptr_r <= ptr_nxt;
        if (ptr_r == PTR_LAST) begin
          wrapped_r <= 1'b1;
        end
        for (int i = 0; i < lpv_pkg::CLASS_COUNT; i++) begin
          tally_r[i] <= tally_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_frame_r <= frame;
    end
  end

  // first strict maximum wins, empty ring gives none
  always_comb begin
    logic [lpv_pkg::TALLY_BITS-1:0] maxc;
    maxc = '0;
    win  = lpv_pkg::CLS_NONE;
    for (int i = 0; i < lpv_pkg::CLASS_COUNT; i++) begin
      if (tally_r[i] > maxc) begin
        maxc = tally_r[i];
        win  = lpv_pkg::lpv_class_t'(lpv_pkg::CLASS_BITS'(i));
      end
    end
  end

  assign res_vld         = e_vld_r;
  assign res.frame       = e_frame_r;
  assign res.voted_class = win;

endmodule

>>> sv/lpv_checker.sv
// port-level checks of the lane position voter and their bind
`include "lane_position_vote_core_assert.svh"

module lpv_checker #(
  parameter int COUNT_BITS = lpv_pkg::COUNT_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lpv_pkg::CLASS_BITS-1:0]    out_frame_class,
  input logic [lpv_pkg::CLASS_BITS-1:0]    out_voted_class,
  input logic [lpv_pkg::MARKS_BITS-1:0]    out_left_marks,
  input logic [lpv_pkg::MARKS_BITS-1:0]    out_right_marks
);

  localparam logic MARKS_EXACT = (COUNT_BITS <= lpv_pkg::MARKS_BITS);
  localparam int   PAYLOAD_W   = 2 * lpv_pkg::CLASS_BITS + 2 * lpv_pkg::MARKS_BITS;

  logic                 seen_r;
  logic                 stall;
  logic                 empty_beat;
  logic                 class_none;
  logic                 first_beat;
  logic [PAYLOAD_W-1:0] payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  assign stall      = out_valid && !out_ready;
  assign payload    = {out_frame_class, out_voted_class, out_left_marks, out_right_marks};
  assign empty_beat = out_valid && MARKS_EXACT && (out_left_marks == '0) &&
                      (out_right_marks == '0);
  assign class_none = (out_frame_class == lpv_pkg::CLS_NONE);
  assign first_beat = out_valid && !seen_r;

  // stalled result beat keeps its payload
  `LPV_ASSERT_CORE(a_out_hold, stall |=> out_valid && $stable(payload), "result beat changed while stalled")

  // the segment side backs off only behind a blocked result
  `LPV_ASSERT_CORE(a_in_block, !in_ready |-> stall, "input blocked without a stalled result")

  // a frame with no marking on either side cannot count as present
  `LPV_ASSERT_CORE(a_empty_frame, empty_beat |-> class_none, "empty frame not classed none")

  // the first frame after reset is the only entry of the ring
  `LPV_ASSERT_CORE(a_first_vote, first_beat |-> out_voted_class == out_frame_class, "first vote differs")

endmodule

bind lane_position_vote_core lpv_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_lpv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_frame_class (out_frame_class),
  .out_voted_class (out_voted_class),
  .out_left_marks  (out_left_marks),
  .out_right_marks (out_right_marks)
);
